### rtl/core/iubt_pkg.sv
`timescale 1ns / 1ps
package iubt_pkg;
  localparam int unsigned MAX_INTERVALS = 256;
  localparam int unsigned IDX_W = $clog2(MAX_INTERVALS);
  localparam int unsigned CNT_W = IDX_W + 1;
  localparam int unsigned TS_W = 64;
  localparam int unsigned Q_DEPTH = 2;

  typedef struct packed {
    logic [TS_W-1:0] interval_start;
    logic [TS_W-1:0] interval_end;
    logic            last_interval;
  } item_t;

  typedef struct packed {
    logic [TS_W-1:0] busy_len;
    logic [TS_W-1:0] span_len;
    logic [TS_W-1:0] idle_len;
    logic            dropped_flag;
  } result_t;

  // Classified item handed from the front part to the back part.
  typedef struct packed {
    logic [TS_W-1:0] interval_start;
    logic [TS_W-1:0] interval_end;
    logic            last_interval;
    logic            empty_iv;
  } cmd_t;
endpackage

### rtl/core/iubt_if.sv
`timescale 1ns / 1ps
interface iubt_item_if;
  import iubt_pkg::*;
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface iubt_result_if;
  import iubt_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/core/interval_union_busy_time_core.sv
`timescale 1ns / 1ps
// Interval union busy-time core. Intervals arrive one per beat and are
// loaded at one per cycle, while the back part is loading, through a
// two-entry queue; every interval takes a slot, empty and reversed ones
// included. The beat carrying the last mark closes the set and starts a
// selection sort by start time over the store, merged with a sweep, whose
// speed is limited by the single read port of the store. The result sits
// in an output register, so the next set can load while it waits; a second
// result waits until the first is taken, and the input stalls once the
// queue is full. Up to 256 intervals are held; more are dropped and flagged.
module interval_union_busy_time_core import iubt_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  iubt_item_if.sink     in_ch,
  iubt_result_if.source out_ch
);
  logic q_valid, q_pop;
  cmd_t q_data;

  iubt_front u_front (.clk, .rst, .in_ch, .q_valid, .q_data, .q_pop);
  iubt_back  u_back  (.clk, .rst, .q_valid, .q_data, .q_pop, .out_ch);

`ifndef ASSERT_OFF
  // The result holds its value until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> $stable(out_ch.data)) else $error("hold");
  // Idle time never exceeds total time.
  a_idle: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.data.idle_len <= out_ch.data.span_len)
    else $error("idle");
`endif
endmodule

### rtl/core/iubt_front.sv
`timescale 1ns / 1ps
module iubt_front import iubt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  iubt_item_if.sink   in_ch,
  output logic        q_valid,
  output cmd_t        q_data,
  input  logic        q_pop
);
  cmd_t               mem [Q_DEPTH];
  logic [0:0]         wp, rp;
  logic [1:0]         cnt;
  logic               push;

  assign in_ch.ready = (cnt != 2'(Q_DEPTH));
  assign push = in_ch.valid && in_ch.ready;
  assign q_valid = (cnt != 2'd0);
  assign q_data = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= '{interval_start: in_ch.data.interval_start,
                   interval_end: in_ch.data.interval_end,
                   last_interval: in_ch.data.last_interval,
                   empty_iv: in_ch.data.interval_end <= in_ch.data.interval_start};
    end
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (q_pop) rp <= rp + 1'b1;
      cnt <= cnt + 2'(push) - 2'(q_pop);
    end
  end
endmodule

### rtl/core/iubt_back.sv
`timescale 1ns / 1ps
module iubt_back import iubt_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  cmd_t          q_data,
  output logic          q_pop,
  iubt_result_if.source out_ch
);
  typedef enum logic [2:0] {S_LOAD, S_SEL, S_RD, S_CMP, S_SWAP, S_SWEEP, S_OUT} state_t;

  logic [TS_W-1:0] st_mem [MAX_INTERVALS];
  logic [TS_W-1:0] en_mem [MAX_INTERVALS];

  state_t          state;
  logic [CNT_W-1:0] cnt;
  logic            ovf;
  logic [TS_W-1:0] lo, hi;
  logic [TS_W-1:0] lo_c, hi_c;
  logic [CNT_W-1:0] i, j, mi;
  logic [TS_W-1:0] ms, me, rs, re;
  logic            wr_en;
  logic            wr_en_next;
  logic [IDX_W-1:0] wr_a;
  logic [TS_W-1:0] wr_s, wr_e;
  logic [TS_W-1:0] run_s, run_e, busy;
  logic            open;
  logic [TS_W-1:0] total;
  logic [TS_W-1:0] busy_c;

  // Selection sort on start time, then a sweep. Empty and reversed intervals
  // are stored so that they take a slot, and the sweep skips them.
  assign q_pop = (state == S_LOAD) && q_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      st_mem[wr_a] <= wr_s;
      en_mem[wr_a] <= wr_e;
    end
    rs <= st_mem[j[IDX_W-1:0]];
    re <= en_mem[j[IDX_W-1:0]];
  end

  always_comb begin
    lo_c = q_data.empty_iv ? q_data.interval_end : q_data.interval_start;
    hi_c = q_data.empty_iv ? q_data.interval_start : q_data.interval_end;
    wr_en_next = ((state == S_LOAD) && q_valid && (cnt != CNT_W'(MAX_INTERVALS)))
                 || (state == S_SWEEP);
    total = hi - lo;
    busy_c = (open ? busy + (run_e - run_s) : busy);
    if (busy_c > total) busy_c = total;
  end

  always_ff @(posedge clk) begin
    wr_en <= wr_en_next && !rst;
    if (rst) begin
      state <= S_LOAD;
      cnt <= '0;
      ovf <= 1'b0;
      lo <= '1;
      hi <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      // The result register frees the back part as soon as it is loaded.
      if (state == S_OUT && (!out_ch.valid || out_ch.ready)) begin
        out_ch.valid <= 1'b1;
        out_ch.data.busy_len <= busy_c;
        out_ch.data.span_len <= total;
        out_ch.data.idle_len <= total - busy_c;
        out_ch.data.dropped_flag <= ovf;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      case (state)
        S_LOAD: if (q_valid) begin
          if (cnt == CNT_W'(MAX_INTERVALS)) ovf <= 1'b1;
          else begin
            wr_a <= cnt[IDX_W-1:0];
            wr_s <= q_data.interval_start;
            wr_e <= q_data.interval_end;
            cnt <= cnt + 1'b1;
            if (lo_c < lo) lo <= lo_c;
            if (hi_c > hi) hi <= hi_c;
          end
          if (q_data.last_interval) begin
            i <= '0;
            busy <= '0;
            open <= 1'b0;
            state <= S_SEL;
          end
        end
        S_SEL: begin
          if (i >= cnt) state <= S_OUT;
          else begin
            j <= i;
            ms <= '1;
            state <= S_RD;
          end
        end
        S_RD: state <= S_CMP;
        S_CMP: begin
          if (rs <= ms) begin
            ms <= rs;
            me <= re;
            mi <= j;
          end
          if (j + 1'b1 >= cnt) begin
            j <= i;
            state <= S_SWAP;
          end else begin
            j <= j + 1'b1;
            state <= S_RD;
          end
        end
        // Entry i is read here.
        S_SWAP: state <= S_SWEEP;
        S_SWEEP: begin
          // rs/re now hold entry i; move it to the minimum's slot.
          wr_a <= mi[IDX_W-1:0];
          wr_s <= rs;
          wr_e <= re;
          if (me > ms) begin
            if (!open) begin
              run_s <= ms; run_e <= me; open <= 1'b1;
            end else if (ms <= run_e) begin
              if (me > run_e) run_e <= me;
            end else begin
              busy <= busy + (run_e - run_s);
              run_s <= ms; run_e <= me;
            end
          end
          i <= i + 1'b1;
          state <= S_SEL;
        end
        S_OUT: begin
          if (!out_ch.valid || out_ch.ready) begin
            cnt <= '0; ovf <= 1'b0; lo <= '1; hi <= '0;
            state <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule
